// File: rtl/mmdp_pkg.sv
// shared types and constants for the matrix dot product block
package mmdp_pkg;

  localparam int ElemW = 32;
  localparam int AccW  = 64;
  localparam int IdxW  = 4;
  localparam int LenW  = 5;

  typedef enum logic [1:0] {
    REQ_WR_A = 2'd0,
    REQ_WR_B = 2'd1,
    REQ_CALC = 2'd2
  } req_type_t;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic [IdxW-1:0]         idx_t;
  typedef logic [LenW-1:0]         len_t;

endpackage

// File: rtl/mmdp_ifs.sv
// request and response channel interfaces
interface mmdp_req_if;
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  mmdp_pkg::idx_t   row;
  mmdp_pkg::idx_t   col;
  mmdp_pkg::elem_t  value;

  modport source (output valid, req_type, row, col, value, input ready);
  modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface mmdp_rsp_if;
  logic            valid;
  logic            ready;
  mmdp_pkg::acc_t  product;

  modport source (output valid, product, input ready);
  modport sink   (input valid, product, output ready);
endinterface

// File: rtl/matrix_multiply_dot_product.sv
// matrix operand stores with one dot product result word per compute request
//
//  channel  dir  payload                      accepted when
//  -------  ---  ---------------------------  ----------------------
//  req      in   req_type, row, col, value    valid && ready
//  rsp      out  product                      valid && ready
//  cfg      in   cfg_data (inner_length)      cfg_we
//
// an element write is stored when it is accepted; a compute request reads
// inner_length terms (saturated to MAX_DIM) through the single read port of
// each store, which delivers one term per cycle into a registered multiplier
// and then the accumulator. out-of-range or empty requests answer zero.
// rst is synchronous; store contents are not cleared. a waiting response
// word does not block element writes; a finished sum waits for a free slot.
module matrix_multiply_dot_product #(
  parameter int MAX_DIM = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  mmdp_pkg::len_t        cfg_data,
  mmdp_req_if.sink              req,
  mmdp_rsp_if.source            rsp
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(Depth);
  localparam int IW    = $clog2(MAX_DIM);
  localparam int LW    = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t               state;
  mmdp_pkg::len_t       inner_length;
  mmdp_pkg::idx_t       row_q;
  mmdp_pkg::idx_t       col_q;
  logic [LW-1:0]        len_q;
  logic [LW-1:0]        term;
  logic                 rd_vld;
  logic                 mul_vld;
  mmdp_pkg::acc_t       prod;
  mmdp_pkg::acc_t       acc;

  logic                 req_fire;
  logic                 req_inside;
  logic                 rsp_load;
  logic [LW-1:0]        len_eff;
  logic                 wr_a;
  logic                 wr_b;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        a_raddr;
  logic [AW-1:0]        b_raddr;
  logic [31:0]          a_rdata;
  logic [31:0]          b_rdata;

  assign req.ready  = (state == S_IDLE);
  assign req_fire   = req.valid && req.ready;
  assign req_inside = (int'(req.row) < MAX_DIM) && (int'(req.col) < MAX_DIM);

  // finished sum moves into the output slot when it is free or draining
  assign rsp_load = (state == S_DONE) && (!rsp.valid || rsp.ready);

  assign len_eff = (int'(inner_length) > MAX_DIM) ? LW'(MAX_DIM) : LW'(inner_length);

  assign wr_a  = req_fire && req_inside && (req.req_type == mmdp_pkg::REQ_WR_A);
  assign wr_b  = req_fire && req_inside && (req.req_type == mmdp_pkg::REQ_WR_B);
  assign waddr = AW'(int'(req.row) * MAX_DIM + int'(req.col));

  // row of a walks along columns, column of b walks down rows
  assign a_raddr = AW'(int'(row_q) * MAX_DIM + int'(term[IW-1:0]));
  assign b_raddr = AW'(int'(term[IW-1:0]) * MAX_DIM + int'(col_q));

  mmdp_ram #(.WIDTH(mmdp_pkg::ElemW), .DEPTH(Depth)) u_a_store (
    .clk   (clk),
    .we    (wr_a),
    .waddr (waddr),
    .wdata (req.value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mmdp_ram #(.WIDTH(mmdp_pkg::ElemW), .DEPTH(Depth)) u_b_store (
    .clk   (clk),
    .we    (wr_b),
    .waddr (waddr),
    .wdata (req.value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      inner_length <= mmdp_pkg::len_t'(16);
      rd_vld       <= 1'b0;
      mul_vld      <= 1'b0;
      rsp.valid    <= 1'b0;
      term         <= '0;
    end else begin
      if (cfg_we) begin
        inner_length <= cfg_data;
      end

      if (rsp_load) begin
        rsp.valid   <= 1'b1;
        rsp.product <= acc;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      rd_vld  <= (state == S_RUN);
      mul_vld <= rd_vld;
      if (rd_vld) begin
        prod <= mmdp_pkg::acc_t'($signed(a_rdata) * $signed(b_rdata));
      end
      if (mul_vld) begin
        acc <= acc + prod;
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire && (req.req_type == mmdp_pkg::REQ_CALC)) begin
            row_q <= req.row;
            col_q <= req.col;
            len_q <= len_eff;
            term  <= '0;
            acc   <= '0;
            // nothing to sum: answer zero straight away
            if (!req_inside || (len_eff == '0)) begin
              state <= S_DONE;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          term <= term + 1'b1;
          if (term == LW'(len_q - 1'b1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_vld && !mul_vld) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/mmdp_ram.sv
// generic single write port ram with registered read
module mmdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sim/mmdp_checker.sv
`timescale 1ns / 1ps
// checker for the matrix dot product block: mirrors both stores, predicts and compares
module mmdp_checker #(
  parameter int Dim = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  mmdp_pkg::len_t cfg_data,
  mmdp_req_if            req,
  mmdp_rsp_if            rsp,
  output int             fails,
  output int             pending
);

  mmdp_pkg::elem_t a_mem [Dim][Dim];
  mmdp_pkg::elem_t b_mem [Dim][Dim];
  mmdp_pkg::len_t  span;
  mmdp_pkg::acc_t  product_q [$];
  int              mismatch_cnt = 0;

  // row r of A times column c of B, wrapping at 64 bits
  function automatic mmdp_pkg::acc_t dot_product_of(input mmdp_pkg::idx_t r,
                                                    input mmdp_pkg::idx_t c);
    mmdp_pkg::acc_t sum;
    int             n;
    sum = '0;
    n = (span > Dim) ? Dim : int'(span);
    for (int t = 0; t < n; t++)
      sum += mmdp_pkg::acc_t'(a_mem[r][t]) * mmdp_pkg::acc_t'(b_mem[t][c]);
    return sum;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      span = 5'd16;
      product_q.delete();
    end else begin
      if (cfg_we)
        span = cfg_data;
      if (req.valid && req.ready) begin
        case (req.req_type)
          mmdp_pkg::REQ_WR_A: a_mem[req.row][req.col] = req.value;
          mmdp_pkg::REQ_WR_B: b_mem[req.row][req.col] = req.value;
          mmdp_pkg::REQ_CALC: product_q.push_back(dot_product_of(req.row, req.col));
          default: ;  // unused code, no effect
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (product_q.size() == 0) begin
          report_mismatch($sformatf("unexpected product word %h", rsp.product));
        end else begin
          if (rsp.product !== product_q[0])
            report_mismatch($sformatf("product %h, expected %h", rsp.product,
                                      product_q[0]));
          void'(product_q.pop_front());
        end
      end
    end
    pending <= product_q.size();
    fails   <= mismatch_cnt;
  end

endmodule

// File: sim/matrix_multiply_dot_product_tb.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, request stimulus, response back-pressure and verdict
module matrix_multiply_dot_product_tb;

  localparam int Dim           = 16;
  localparam int Limit         = 200000;
  localparam int HoldCycles    = 400;
  localparam int HoldAfter     = 200;
  localparam int SettleCycles  = 40;
  localparam int ItemsPerPhase = 69;
  localparam int NumPhases     = 8;
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam mmdp_pkg::len_t Lengths [NumPhases] = '{5'd16, 5'd2, 5'd31, 5'd9, 5'd0,
                                                     5'd17, 5'd1, 5'd16};

  logic           clk = 1'b0;
  logic           rst;
  logic           cfg_we;
  mmdp_pkg::len_t cfg_data;
  int             fails;
  int             pending;

  mmdp_req_if req_ch ();
  mmdp_rsp_if rsp_ch ();

  bit             a_done [Dim][Dim];
  bit             b_done [Dim][Dim];
  mmdp_pkg::len_t cur_len;
  bit             calm = 1'b0;
  bit             held_off = 1'b0;
  int             sent = 0;
  int             calcs = 0;
  int             cycles;

  matrix_multiply_dot_product #(
    .MAX_DIM (Dim)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  mmdp_checker #(
    .Dim (Dim)
  ) u_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .fails    (fails),
    .pending  (pending)
  );

  always #1 clk = ~clk;

  function automatic mmdp_pkg::elem_t rand_elem();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return '1;
      default: return mmdp_pkg::elem_t'($urandom);
    endcase
  endfunction

  // offer one request word and hold it until accepted
  task automatic send_word(input logic [1:0] kind, input mmdp_pkg::idx_t r,
                           input mmdp_pkg::idx_t c, input mmdp_pkg::elem_t v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.row      <= r;
    req_ch.col      <= c;
    req_ch.value    <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    if (kind == mmdp_pkg::REQ_WR_A) a_done[r][c] = 1'b1;
    if (kind == mmdp_pkg::REQ_WR_B) b_done[r][c] = 1'b1;
  endtask

  // fill any unwritten operand the dot product would read, then request it
  task automatic send_compute(input mmdp_pkg::idx_t r, input mmdp_pkg::idx_t c);
    int n;
    n = (cur_len > Dim) ? Dim : int'(cur_len);
    for (int t = 0; t < n; t++) begin
      if (!a_done[r][t])
        send_word(mmdp_pkg::REQ_WR_A, r, mmdp_pkg::idx_t'(t), rand_elem());
      if (!b_done[t][c])
        send_word(mmdp_pkg::REQ_WR_B, mmdp_pkg::idx_t'(t), c, rand_elem());
    end
    send_word(mmdp_pkg::REQ_CALC, r, c, rand_elem());
    calcs++;
  endtask

  // change inner length only once the block has drained
  task automatic set_length(input mmdp_pkg::len_t n);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_len = n;
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)
      send_word(ReqUnused, mmdp_pkg::idx_t'($urandom), mmdp_pkg::idx_t'($urandom),
                rand_elem());
    else if (pick < 24)
      send_word(mmdp_pkg::REQ_WR_A, mmdp_pkg::idx_t'($urandom),
                mmdp_pkg::idx_t'($urandom), rand_elem());
    else if (pick < 40)
      send_word(mmdp_pkg::REQ_WR_B, mmdp_pkg::idx_t'($urandom),
                mmdp_pkg::idx_t'($urandom), rand_elem());
    else
      send_compute(mmdp_pkg::idx_t'($urandom), mmdp_pkg::idx_t'($urandom));
  endtask

  // response side back-pressure, with one long hold-off to fill the block
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held_off && sent >= HoldAfter) begin
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        for (int k = 0; k < HoldCycles; k++) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    for (cycles = 0; cycles < Limit; cycles++) @(posedge clk);
    $display("timeout after %0d cycles", Limit);
    $display("FAIL");
    $finish;
  end

  initial begin
    int base;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= mmdp_pkg::REQ_WR_A;
    req_ch.row      <= '0;
    req_ch.col      <= '0;
    req_ch.value    <= '0;
    cur_len = 5'd16;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // extremes of the element range with a one-term sum
    set_length(5'd1);
    send_word(mmdp_pkg::REQ_WR_A, 4'd0, 4'd0, 32'sh7fffffff);
    send_word(mmdp_pkg::REQ_WR_B, 4'd0, 4'd0, 32'sh7fffffff);
    send_compute(4'd0, 4'd0);
    send_word(mmdp_pkg::REQ_WR_A, 4'd15, 4'd0, 32'sh80000000);
    send_word(mmdp_pkg::REQ_WR_B, 4'd0, 4'd15, 32'sh80000000);
    send_compute(4'd15, 4'd15);
    send_compute(4'd0, 4'd15);
    send_compute(4'd15, 4'd0);
    send_word(mmdp_pkg::REQ_WR_A, 4'd1, 4'd0, '1);
    send_word(mmdp_pkg::REQ_WR_B, 4'd0, 4'd1, '0);
    send_compute(4'd1, 4'd1);
    send_compute(4'd1, 4'd0);
    // unused code must leave A[0][0] alone
    send_word(ReqUnused, 4'd0, 4'd0, '0);
    send_compute(4'd0, 4'd0);
    // empty sum
    set_length(5'd0);
    send_compute(4'd5, 4'd7);

    base = sent;
    for (int p = 0; p < NumPhases; p++) begin
      set_length(Lengths[p]);
      if (p == NumPhases - 1) calm = 1'b1;
      while (sent < base + (p + 1) * ItemsPerPhase) random_item();
    end

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("run covered %0d request words, %0d of them dot product requests", sent, calcs);
    $display("inner length swept 0 to 31 with a %0d-cycle response hold-off", HoldCycles);
    if (fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
